// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk and disabled while rst_n is low; NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Types, limits and calendar helpers shared by the second tick clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stc_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 112;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL = 3'd6;

  localparam logic [32:0] MS_PER_SEC   = 33'd1000;
  localparam logic [6:0]  SEC_LIMIT    = 7'd60;
  localparam logic [6:0]  MIN_LIMIT    = 7'd60;
  localparam logic [5:0]  HOUR_LIMIT   = 6'd24;
  localparam logic [4:0]  MONTH_LIMIT  = 5'd13;

  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;

  localparam logic [5:0]  END_FEB      = 6'd29;
  localparam logic [5:0]  END_FEB_LEAP = 6'd30;
  localparam logic [5:0]  END_SHORT    = 6'd31;
  localparam logic [5:0]  END_LONG     = 6'd32;

  localparam logic [4:0]  START_DAY   = 5'd1;
  localparam logic [3:0]  START_MONTH = 4'd1;
  localparam logic [13:0] START_YEAR  = 14'd2023;

  // floor(y / 25) = (y * DIV25_MAGIC) >> 21 for any 14-bit y
  localparam logic [16:0] DIV25_MAGIC = 17'd83887;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [31:0] serial;
  } cal_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [15:0] days;
  } up_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [30:0] prod;
    logic [9:0]  q;
    logic [13:0] q25;
    logic [13:0] rem;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = {17'd0, y} * {14'd0, DIV25_MAGIC};
    q     = prod[30:21];
    q25   = {q, 4'b0000} + {1'b0, q, 3'b000} + {4'd0, q};
    rem   = y - q25;
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (rem == 14'd0);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [5:0] month_end_plus_one(input logic [3:0] m,
                                                    input logic [13:0] y);
    logic [5:0] res;
    res = END_LONG;
    if (m == MONTH_FEB) begin
      res = is_leap(y) ? END_FEB_LEAP : END_FEB;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      res = END_SHORT;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/stc_advance.sv =====
// ----------------------------------------------------------------------------
// stc_advance
// One-second step of the calendar clock, serial counter and uptime counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_advance (
  input  stc_pkg::cal_t cal_i,
  input  stc_pkg::up_t  up_i,
  output stc_pkg::cal_t cal_o,
  output stc_pkg::up_t  up_o
);
  import stc_pkg::*;

  logic [6:0] c_sec1;
  logic [6:0] c_min1;
  logic [5:0] c_hour1;
  logic [5:0] c_day1;
  logic [4:0] c_month1;
  logic [5:0] c_end;
  logic       c_roll_s;
  logic       c_roll_m;
  logic       c_roll_h;
  logic       c_roll_d;
  logic       c_roll_mo;

  logic [6:0] u_sec1;
  logic [6:0] u_min1;
  logic [5:0] u_hour1;
  logic       u_roll_s;
  logic       u_roll_m;
  logic       u_roll_h;

  always_comb begin
    cal_o        = cal_i;
    cal_o.serial = cal_i.serial + 32'd1;

    c_sec1   = {1'b0, cal_i.sec} + 7'd1;
    c_roll_s = (c_sec1 >= SEC_LIMIT);
    cal_o.sec = c_roll_s ? 6'd0 : c_sec1[5:0];

    c_min1   = c_roll_s ? ({1'b0, cal_i.min} + 7'd1) : {1'b0, cal_i.min};
    c_roll_m = (c_min1 >= MIN_LIMIT);
    cal_o.min = c_roll_m ? 6'd0 : c_min1[5:0];

    c_hour1  = c_roll_m ? ({1'b0, cal_i.hour} + 6'd1) : {1'b0, cal_i.hour};
    c_roll_h = (c_hour1 >= HOUR_LIMIT);
    cal_o.hour = c_roll_h ? 5'd0 : c_hour1[4:0];

    c_end     = month_end_plus_one(cal_i.month, cal_i.year);
    c_day1    = {1'b0, cal_i.day} + 6'd1;
    c_roll_d  = (c_day1 >= c_end);
    c_month1  = c_roll_d ? ({1'b0, cal_i.month} + 5'd1) : {1'b0, cal_i.month};
    c_roll_mo = (c_month1 >= MONTH_LIMIT);

    // date moves only at midnight
    if (c_roll_h) begin
      cal_o.day   = c_roll_d ? START_DAY : c_day1[4:0];
      cal_o.month = c_roll_mo ? START_MONTH : c_month1[3:0];
      cal_o.year  = c_roll_mo ? (cal_i.year + 14'd1) : cal_i.year;
    end
  end

  always_comb begin
    up_o = up_i;

    u_sec1   = {1'b0, up_i.sec} + 7'd1;
    u_roll_s = (u_sec1 >= SEC_LIMIT);
    up_o.sec = u_roll_s ? 6'd0 : u_sec1[5:0];

    u_min1   = u_roll_s ? ({1'b0, up_i.min} + 7'd1) : {1'b0, up_i.min};
    u_roll_m = (u_min1 >= MIN_LIMIT);
    up_o.min = u_roll_m ? 6'd0 : u_min1[5:0];

    u_hour1  = u_roll_m ? ({1'b0, up_i.hour} + 6'd1) : {1'b0, up_i.hour};
    u_roll_h = (u_hour1 >= HOUR_LIMIT);
    up_o.hour = u_roll_h ? 5'd0 : u_hour1[4:0];
    up_o.days = u_roll_h ? (up_i.days + 16'd1) : up_i.days;
  end

endmodule

// ===== hw/rtl/second_tick_calendar_clock_unit.sv =====
// ----------------------------------------------------------------------------
// second_tick_calendar_clock_unit
// Counts seconds from millisecond samples and keeps calendar and uptime time.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, then the result
// register; out_tvalid rises when the result register is loaded.
// Throughput: one request per cycle while the result register is free or out_tready is high.
// The cycle is set by the 33-bit elapsed-plus-carry add and the date rollover.
// Reset (rst_n low, synchronous): clock loads 00:00:00 1/1/2023, serial 0,
// uptime and millisecond remainder cleared, both stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module second_tick_calendar_clock_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [stc_pkg::IN_W-1:0]       in_tdata,   // [31:0] now_ms
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] second_tick, [6:1] cal_second, [12:7] cal_minute, [17:13] cal_hour,
  // [22:18] cal_day, [26:23] cal_month, [40:27] cal_year,
  // [72:41] serial_seconds, [78:73] up_second, [84:79] up_minute,
  // [89:85] up_hour, [105:90] up_days, [111:106] zero
  output logic [stc_pkg::OUT_W-1:0]      out_tdata,
  input  logic                           cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::CFG_W-1:0]      cfg_wdata
);
  import stc_pkg::*;

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [IN_W-1:0]   in_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;

  logic [31:0]       last_ms_r;
  logic [31:0]       last_ms_nxt;
  logic [31:0]       carry_r;
  logic [31:0]       carry_nxt;
  cal_t              cal_r;
  cal_t              cal_nxt;
  up_t               up_r;
  up_t               up_nxt;

  cal_t              cal_adv;
  up_t               up_adv;
  cal_t              res_cal;
  up_t               res_up;

  logic              in_fire;
  logic              stage_ok;
  logic              proc;
  logic [31:0]       delta;
  logic [32:0]       sum;
  logic [32:0]       rest;
  logic              tick;

  stc_advance u_advance (
    .cal_i (cal_r),
    .up_i  (up_r),
    .cal_o (cal_adv),
    .up_o  (up_adv)
  );

  assign stage_ok  = !out_valid_r || out_tready;
  assign proc      = in_valid_r && stage_ok;
  assign in_tready = !in_valid_r || stage_ok;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    delta = in_data_r - last_ms_r;
    sum   = {1'b0, delta} + {1'b0, carry_r};
    tick  = (sum >= MS_PER_SEC);
    rest  = sum - MS_PER_SEC;
  end

  assign res_cal = tick ? cal_adv : cal_r;
  assign res_up  = tick ? up_adv : up_r;

  always_comb begin
    in_valid_nxt  = in_fire ? 1'b1 : (proc ? 1'b0 : in_valid_r);
    out_valid_nxt = proc ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

    last_ms_nxt = last_ms_r;
    carry_nxt   = carry_r;
    cal_nxt     = cal_r;
    up_nxt      = up_r;

    if (proc && tick) begin
      last_ms_nxt = in_data_r;
      carry_nxt   = rest[32] ? 32'hFFFF_FFFF : rest[31:0];
      cal_nxt     = cal_adv;
      up_nxt      = up_adv;
    end

    // set: load the written field straight into the running clock
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECOND: cal_nxt.sec    = cfg_wdata[5:0];
        CFG_MINUTE: cal_nxt.min    = cfg_wdata[5:0];
        CFG_HOUR:   cal_nxt.hour   = cfg_wdata[4:0];
        CFG_DAY:    cal_nxt.day    = cfg_wdata[4:0];
        CFG_MONTH:  cal_nxt.month  = cfg_wdata[3:0];
        CFG_YEAR:   cal_nxt.year   = cfg_wdata[13:0];
        CFG_SERIAL: cal_nxt.serial = cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_ms_r   <= 32'd0;
      carry_r     <= 32'd0;
      cal_r       <= '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: START_DAY,
                       month: START_MONTH, year: START_YEAR, serial: 32'd0};
      up_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_ms_r   <= last_ms_nxt;
      carry_r     <= carry_nxt;
      cal_r       <= cal_nxt;
      up_r        <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
    end
    if (proc) begin
      out_data_r <= {6'd0, res_up.days, res_up.hour, res_up.min, res_up.sec,
                     res_cal.serial, res_cal.year, res_cal.month, res_cal.day,
                     res_cal.hour, res_cal.min, res_cal.sec, tick};
    end
  end

  `ASSERT_IMPLIES(a_hold_when_full, in_valid_r && out_valid_r && !out_tready, !in_tready)
  `ASSERT_NEXT(a_no_tick_keeps_time, proc && !tick && !cfg_we, $stable(cal_r) && $stable(up_r))
  `ASSERT_NEXT(a_tick_bumps_serial, proc && tick && !cfg_we, cal_r.serial == $past(cal_r.serial) + 32'd1)

endmodule

// ===== tb/second_tick_calendar_clock_unit_tb.sv =====
// ----------------------------------------------------------------------------
// second_tick_calendar_clock_unit_tb
// Self-checking bench for the millisecond-to-second calendar clock. A short
// table covers reset values, wrap of every calendar field, leap-year rules,
// out-of-range register loads and the ignored register index. Random
// millisecond streams then run under changing clock settings and random
// stalls on both sides. A final burst drives huge jumps that saturate the
// remainder. Every request yields one result, which is compared field by field
// against a table row's given reading, else a behavioral model in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module second_tick_calendar_clock_unit_tb;
  import stc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int SEG_COUNT   = 7;
  localparam int SEG_SAMPLES = 48;
  localparam int TAIL_NOISE  = 25;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // laid out as out_tdata, highest bits first
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] up_days;
    logic [4:0]  up_hour;
    logic [5:0]  up_minute;
    logic [5:0]  up_second;
    logic [31:0] serial;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        tick;
  } reading_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
    logic                 has_want;
    reading_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // clock model state
  logic [31:0] ms_mark;
  logic [31:0] ms_rem;
  int unsigned up_sec, up_min, up_hour, up_days;
  int unsigned cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;
  logic [31:0] cal_serial;

  reading_t  readings_due[$];
  plan_row_t plan[$];
  logic [31:0] last_sent = '0;
  int send_idle_pct  = 33;
  int recv_stall_pct = 60;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  second_tick_calendar_clock_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit leap(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned month_limit(input int unsigned m, input int unsigned y);
    if (m == MONTH_FEB) return leap(y) ? 30 : 29;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 31;
    return 32;
  endfunction

  function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [31:0] val);
    case (idx)
      CFG_SECOND: cal_sec    = val[5:0];
      CFG_MINUTE: cal_min    = val[5:0];
      CFG_HOUR:   cal_hour   = val[4:0];
      CFG_DAY:    cal_day    = val[4:0];
      CFG_MONTH:  cal_month  = val[3:0];
      CFG_YEAR:   cal_year   = val[13:0];
      CFG_SERIAL: cal_serial = val;
      default: ;
    endcase
  endfunction

  function automatic reading_t tick_clock(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [32:0] total;
    logic [32:0] rest;
    reading_t    r;
    elapsed = now - ms_mark;
    total   = {1'b0, elapsed} + {1'b0, ms_rem};
    r       = '0;
    if (total >= 33'd1000) begin
      rest    = total - 33'd1000;
      ms_mark = now;
      ms_rem  = rest[32] ? 32'hFFFF_FFFF : rest[31:0];
      r.tick  = 1'b1;
      up_sec++;
      if (up_sec >= 60) begin up_sec = 0; up_min++; end
      if (up_min >= 60) begin up_min = 0; up_hour++; end
      if (up_hour >= 24) begin up_hour = 0; up_days = (up_days + 1) % 65536; end
      cal_serial = cal_serial + 32'd1;
      cal_sec++;
      if (cal_sec >= 60) begin cal_sec = 0; cal_min++; end
      if (cal_min >= 60) begin cal_min = 0; cal_hour++; end
      if (cal_hour >= 24) begin
        cal_hour = 0;
        cal_day++;
        if (cal_day >= month_limit(cal_month, cal_year)) begin
          cal_day = 1;
          cal_month++;
        end
        if (cal_month >= 13) begin
          cal_month = 1;
          cal_year  = (cal_year + 1) % 16384;
        end
      end
    end
    r.second    = 6'(cal_sec);
    r.minute    = 6'(cal_min);
    r.hour      = 5'(cal_hour);
    r.day       = 5'(cal_day);
    r.month     = 4'(cal_month);
    r.year      = 14'(cal_year);
    r.serial    = cal_serial;
    r.up_second = 6'(up_sec);
    r.up_minute = 6'(up_min);
    r.up_hour   = 5'(up_hour);
    r.up_days   = 16'(up_days);
    return r;
  endfunction

  function automatic reading_t reading(input int unsigned tick, sec, min, hour, day, month,
                                       year, serial, usec, umin, uhour, udays);
    reading_t r;
    r           = '0;
    r.tick      = tick[0];
    r.second    = 6'(sec);
    r.minute    = 6'(min);
    r.hour      = 5'(hour);
    r.day       = 5'(day);
    r.month     = 4'(month);
    r.year      = 14'(year);
    r.serial    = serial;
    r.up_second = 6'(usec);
    r.up_minute = 6'(umin);
    r.up_hour   = 5'(uhour);
    r.up_days   = 16'(udays);
    return r;
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] field, input int width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 32'd1;
    if ($urandom_range(1) == 0) return field;
    return ($urandom & ~mask) | (field & mask);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    plan.push_back('{ROW_WRITE, idx, val, 1'b0, '0});
  endfunction

  function automatic void add_sample(input logic [31:0] now, input logic has_want = 1'b0,
                                     input reading_t want = '0);
    plan.push_back('{ROW_SAMPLE, CFG_SECOND, now, has_want, want});
  endfunction

  // park the clock one second before midnight on the given date
  function automatic void add_midnight(input int unsigned day, month, year);
    add_write(CFG_SECOND, 32'd59);
    add_write(CFG_MINUTE, 32'd59);
    add_write(CFG_HOUR, 32'd23);
    add_write(CFG_DAY, day);
    add_write(CFG_MONTH, month);
    add_write(CFG_YEAR, year);
  endfunction

  task automatic send_request(input logic [31:0] now, input logic has_want,
                              input reading_t want);
    reading_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = tick_clock(now);
    readings_due.push_back(has_want ? want : predicted);
    last_sent = now;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    load_register(idx, val);
    @(negedge clk);
  endtask

  task automatic walk_plan();
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) wait_drained();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        cfg_we <= 1'b0;
        send_request(plan[i].value, plan[i].has_want, plan[i].want);
      end
    end
    plan.delete();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : result_check
    reading_t seen;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      if (readings_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        check_field("second_tick", want.tick, seen.tick);
        check_field("cal_second", want.second, seen.second);
        check_field("cal_minute", want.minute, seen.minute);
        check_field("cal_hour", want.hour, seen.hour);
        check_field("cal_day", want.day, seen.day);
        check_field("cal_month", want.month, seen.month);
        check_field("cal_year", want.year, seen.year);
        check_field("serial_seconds", want.serial, seen.serial);
        check_field("up_second", want.up_second, seen.up_second);
        check_field("up_minute", want.up_minute, seen.up_minute);
        check_field("up_hour", want.up_hour, seen.up_hour);
        check_field("up_days", want.up_days, seen.up_days);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    reading_t    no_reading;
    reading_t    at_reset;
    logic [31:0] stride;
    logic [31:0] base;
    logic [31:0] serial_v;
    int unsigned sec_v, min_v, hour_v, day_v, month_v, year_v;
    int unsigned roll;

    no_reading = '0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SECOND;
    cfg_wdata  = '0;
    ms_mark    = '0;
    ms_rem     = '0;
    up_sec     = 0;
    up_min     = 0;
    up_hour    = 0;
    up_days    = 0;
    cal_sec    = 0;
    cal_min    = 0;
    cal_hour   = 0;
    cal_day    = 1;
    cal_month  = 1;
    cal_year   = 2023;
    cal_serial = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    at_reset = reading(0, 0, 0, 0, 1, 1, 2023, 0, 0, 0, 0, 0);
    add_sample(32'd0, 1'b1, at_reset);
    add_sample(32'd999, 1'b1, at_reset);
    add_sample(32'd1000, 1'b1, reading(1, 1, 0, 0, 1, 1, 2023, 1, 1, 0, 0, 0));
    add_sample(32'd1000);
    add_sample(32'd2999);
    add_sample(32'd3000);
    add_midnight(31, 12, 16383);
    add_write(CFG_SERIAL, 32'hFFFF_FFFF);
    add_sample(32'd4000, 1'b1, reading(1, 0, 0, 0, 1, 1, 0, 0, 4, 0, 0, 0));
    add_midnight(28, MONTH_FEB, 2024);
    add_sample(32'd5000);
    add_midnight(29, MONTH_FEB, 2024);
    add_sample(32'd6000);
    add_midnight(28, MONTH_FEB, 2023);
    add_sample(32'd7000);
    add_midnight(28, MONTH_FEB, 1900);
    add_sample(32'd8000);
    add_midnight(28, MONTH_FEB, 2000);
    add_sample(32'd9000);
    add_midnight(30, MONTH_APR, 2000);
    add_sample(32'd10000);
    add_midnight(0, 0, 2000);
    add_sample(32'd11000);
    add_midnight(31, 15, 2000);
    add_sample(32'd12000);
    add_write(CFG_SECOND, 32'd63);
    add_write(CFG_MINUTE, 32'd63);
    add_write(CFG_HOUR, 32'd31);
    add_sample(32'd13000);
    add_write(CFG_UNUSED, $urandom);
    add_sample(32'd14000);
    walk_plan();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 60 : 0;
      recv_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 33 : 0;
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
        wait_drained();
        case ($urandom_range(10))
          0:       year_v = 0;
          1:       year_v = 1900;
          2:       year_v = 2000;
          3:       year_v = 2023;
          4:       year_v = 2024;
          5:       year_v = 2100;
          6:       year_v = 2400;
          7:       year_v = 9999;
          8:       year_v = 16383;
          default: year_v = $urandom_range(16383);
        endcase
        month_v = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(15);
        roll = $urandom_range(99);
        if (roll < 50) day_v = month_limit(month_v, year_v) - 1;
        else if (roll < 90) day_v = $urandom_range(31, 1);
        else day_v = $urandom_range(31);
        roll = $urandom_range(99);
        if (roll < 60) hour_v = 23;
        else if (roll < 90) hour_v = $urandom_range(23);
        else hour_v = $urandom_range(31);
        roll = $urandom_range(99);
        if (roll < 60) min_v = 59;
        else if (roll < 90) min_v = $urandom_range(59);
        else min_v = $urandom_range(63);
        roll = $urandom_range(99);
        if (roll < 70) sec_v = $urandom_range(59, 30);
        else if (roll < 90) sec_v = $urandom_range(63);
        else sec_v = 0;
        roll = $urandom_range(99);
        if (roll < 30) serial_v = 32'hFFFF_FFFF - $urandom_range(40);
        else if (roll < 45) serial_v = '0;
        else serial_v = $urandom;

        write_reg(CFG_SECOND, with_junk(sec_v, 6));
        write_reg(CFG_MINUTE, with_junk(min_v, 6));
        write_reg(CFG_HOUR, with_junk(hour_v, 5));
        write_reg(CFG_DAY, with_junk(day_v, 5));
        write_reg(CFG_MONTH, with_junk(month_v, 4));
        write_reg(CFG_YEAR, with_junk(year_v, 14));
        write_reg(CFG_SERIAL, serial_v);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;

        // mostly steady sampling; repeats, fine steps and missed seconds mixed in
        for (int k = 0; k < SEG_SAMPLES; k++) begin
          roll = $urandom_range(99);
          if (roll < 10) stride = '0;
          else if (roll < 17) stride = $urandom_range(40, 1);
          else if (roll < 70) stride = $urandom_range(999, 1);
          else if (roll < 97) stride = $urandom_range(1400, 1000);
          else stride = $urandom_range(2999, 2000);
          send_request(last_sent + stride, 1'b0, no_reading);
        end
      end
    end

    // saturate the remainder, then sweep the full sample range
    base = ms_mark;
    add_sample(base - 32'd1);
    add_sample(base - 32'd2);
    add_sample(base - 32'd2);
    add_sample(32'd0);
    add_sample(32'hFFFF_FFFF);
    repeat (TAIL_NOISE) add_sample($urandom);
    walk_plan();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
